// File: sv/kvt_pkg.sv
// shared types and constants of the key/value string tokenizer
package kvt_pkg;

   typedef enum logic [2:0] {
      PH_NAME   = 3'd0,
      PH_VAL    = 3'd1,
      PH_VALQ   = 3'd2,
      PH_ESC    = 3'd3,
      PH_ESCQ   = 3'd4,
      PH_CLOSED = 3'd5,
      PH_SKIP   = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      TK_NAME_CHAR  = 3'd0,
      TK_NAME_END   = 3'd1,
      TK_VALUE_CHAR = 3'd2,
      TK_VALUE_END  = 3'd3,
      TK_DONE_OK    = 3'd4,
      TK_DONE_ERR   = 3'd5
   } token_kind_type;

   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] SEP_RESET = 8'h3B;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [1:0]                 cnt;
      token_kind_type [2:0]       kind;
      logic [7:0]                 chr;
   } token_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: sv/key_value_string_tokenizer_core.sv
// top level of the key/value string tokenizer: front end, entry queue, token sequencer
//
//  beat      | ports                                  | moves
//  ----------+----------------------------------------+----------------------------------
//  request   | req_valid req_ready req_char_in        | one string byte and last-byte flag
//            | req_is_final                           |
//  response  | rsp_valid rsp_ready rsp_token_kind     | one token, run_end on the last one
//            | rsp_token_char rsp_run_end             | caused by a byte
//  csr       | csr_wr_en csr_wr_data                  | pair separator, written at once
//
// a byte is parsed in the cycle it is accepted; its tokens are queued, then registered out
// the response side sends one token per cycle unless rsp_ready stalls; a byte causes
// zero to three tokens; without stalls, bytes of one token or none pass at one per cycle
// the entry queue (QueueDepth entries) lets the request side run on while responses stall
// synchronous active-high reset; separator resets to semicolon, parser to the name phase
module key_value_string_tokenizer_core #(
   parameter int QueueDepth = kvt_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_in,
   input  logic       req_is_final,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_token_kind,
   output logic [7:0] rsp_token_char,
   output logic       rsp_run_end,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   kvt_pkg::queue_status_type q_stat;
   kvt_pkg::token_entry_type  q_entry;
   kvt_pkg::token_entry_type  q_head;
   kvt_pkg::phase_type        phase;
   logic                      q_push;
   logic                      q_pop;

   kvt_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_char_in  (req_char_in),
      .req_is_final (req_is_final),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .q_stat       (q_stat),
      .q_push       (q_push),
      .q_entry      (q_entry),
      .phase        (phase)
   );

   kvt_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .stat       (q_stat)
   );

   kvt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (q_head),
      .q_stat         (q_stat),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_token_kind (rsp_token_kind),
      .rsp_token_char (rsp_token_char),
      .rsp_run_end    (rsp_run_end)
   );

   // no push into a full queue, no pop from an empty one
   assert property (@(posedge clock) disable iff (reset)
      (q_push |-> !q_stat.full) and (q_pop |-> !q_stat.empty))
      else $error("queue overflow or underflow");

   // a verdict always closes the tokens of its byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == kvt_pkg::TK_DONE_OK ||
                    rsp_token_kind == kvt_pkg::TK_DONE_ERR) |-> rsp_run_end)
      else $error("verdict not marked as last token");

   // the last byte of a string returns the parser to the name phase
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_is_final |=> phase == kvt_pkg::PH_NAME)
      else $error("parser not in name phase after last byte");

endmodule

// File: sv/kvt_front.sv
// front end: accepts string bytes, runs the parse state machine, builds token entries
module kvt_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_char_in,
   input  logic                     req_is_final,
   input  logic                     csr_wr_en,
   input  logic [7:0]               csr_wr_data,
   input  kvt_pkg::queue_status_type q_stat,
   output logic                     q_push,
   output kvt_pkg::token_entry_type q_entry,
   output kvt_pkg::phase_type       phase
);

   kvt_pkg::phase_type      phase_ff, phase_in, phase_mid;
   logic                    started_ff, started_in, started_mid;
   logic [7:0]              sep_ff;
   logic                    accept;
   logic                    failed;
   logic                    body_valid;
   kvt_pkg::token_kind_type body_kind;
   logic [7:0]              body_chr;
   logic [1:0]              tail_cnt;
   kvt_pkg::token_kind_type tail0, tail1;

   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;
   assign phase     = phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= kvt_pkg::PH_NAME;
         started_ff <= 1'b0;
         sep_ff     <= kvt_pkg::SEP_RESET;
      end else begin
         if (accept) begin
            phase_ff   <= phase_in;
            started_ff <= started_in;
         end
         if (csr_wr_en) begin
            sep_ff <= csr_wr_data;
         end
      end
   end

   always_comb begin
      body_valid  = 1'b0;
      body_kind   = kvt_pkg::TK_NAME_CHAR;
      body_chr    = '0;
      failed      = 1'b0;
      phase_mid   = phase_ff;
      started_mid = started_ff;
      unique case (phase_ff)
         kvt_pkg::PH_NAME: begin
            body_valid = 1'b1;
            if (req_char_in == kvt_pkg::CH_EQ) begin
               body_kind   = kvt_pkg::TK_NAME_END;
               phase_mid   = kvt_pkg::PH_VAL;
               started_mid = 1'b0;
            end else begin
               body_kind   = kvt_pkg::TK_NAME_CHAR;
               body_chr    = req_char_in;
               started_mid = 1'b1;
            end
         end
         kvt_pkg::PH_VAL: begin
            if (req_char_in == sep_ff) begin
               body_valid  = 1'b1;
               body_kind   = kvt_pkg::TK_VALUE_END;
               phase_mid   = kvt_pkg::PH_NAME;
               started_mid = 1'b0;
            end else if (req_char_in == kvt_pkg::CH_QUOTE) begin
               phase_mid = kvt_pkg::PH_VALQ;
            end else if (req_char_in == kvt_pkg::CH_BSLASH) begin
               phase_mid = kvt_pkg::PH_ESC;
            end else begin
               body_valid = 1'b1;
               body_kind  = kvt_pkg::TK_VALUE_CHAR;
               body_chr   = req_char_in;
            end
         end
         kvt_pkg::PH_VALQ: begin
            if (req_char_in == kvt_pkg::CH_QUOTE) begin
               phase_mid = kvt_pkg::PH_CLOSED;
            end else if (req_char_in == kvt_pkg::CH_BSLASH) begin
               phase_mid = kvt_pkg::PH_ESCQ;
            end else begin
               body_valid = 1'b1;
               body_kind  = kvt_pkg::TK_VALUE_CHAR;
               body_chr   = req_char_in;
            end
         end
         kvt_pkg::PH_ESC: begin
            body_valid = 1'b1;
            body_kind  = kvt_pkg::TK_VALUE_CHAR;
            body_chr   = req_char_in;
            phase_mid  = kvt_pkg::PH_VAL;
         end
         kvt_pkg::PH_ESCQ: begin
            body_valid = 1'b1;
            body_kind  = kvt_pkg::TK_VALUE_CHAR;
            body_chr   = req_char_in;
            phase_mid  = kvt_pkg::PH_VALQ;
         end
         kvt_pkg::PH_CLOSED: begin
            body_valid = 1'b1;
            if (req_char_in == sep_ff) begin
               body_kind   = kvt_pkg::TK_VALUE_END;
               phase_mid   = kvt_pkg::PH_NAME;
               started_mid = 1'b0;
            end else begin
               body_kind = kvt_pkg::TK_DONE_ERR;
               phase_mid = kvt_pkg::PH_SKIP;
               failed    = 1'b1;
            end
         end
         default: begin
            failed = 1'b1;
         end
      endcase

      tail_cnt   = 2'd0;
      tail0      = kvt_pkg::TK_DONE_OK;
      tail1      = kvt_pkg::TK_DONE_OK;
      phase_in   = phase_mid;
      started_in = started_mid;
      if (req_is_final) begin
         if (!failed) begin
            if (phase_mid == kvt_pkg::PH_NAME) begin
               tail_cnt = 2'd1;
               tail0    = started_mid ? kvt_pkg::TK_DONE_ERR : kvt_pkg::TK_DONE_OK;
            end else begin
               tail_cnt = 2'd2;
               tail0    = kvt_pkg::TK_VALUE_END;
               tail1    = kvt_pkg::TK_DONE_OK;
            end
         end
         phase_in   = kvt_pkg::PH_NAME;
         started_in = 1'b0;
      end

      q_entry.chr = body_chr;
      if (body_valid) begin
         q_entry.cnt     = tail_cnt + 2'd1;
         q_entry.kind[0] = body_kind;
         q_entry.kind[1] = tail0;
         q_entry.kind[2] = tail1;
      end else begin
         q_entry.cnt     = tail_cnt;
         q_entry.kind[0] = tail0;
         q_entry.kind[1] = tail1;
         q_entry.kind[2] = kvt_pkg::TK_DONE_OK;
      end
      q_push = accept && (q_entry.cnt != 2'd0);
   end

endmodule

// File: sv/kvt_queue.sv
// short entry queue between the parse front end and the token sequencer
module kvt_queue #(
   parameter int Depth = kvt_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  kvt_pkg::token_entry_type  push_entry,
   input  logic                      pop,
   output kvt_pkg::token_entry_type  head,
   output kvt_pkg::queue_status_type stat
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   kvt_pkg::token_entry_type entries_ff [Depth];
   logic [PtrW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]          count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head       = entries_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == CntW'(Depth));
   assign stat.empty = (count_ff == '0);

endmodule

// File: sv/kvt_back.sv
// back end: steps through each queued entry and drives one token beat per cycle unless rsp_ready stalls it
module kvt_back (
   input  logic                      clock,
   input  logic                      reset,
   input  kvt_pkg::token_entry_type  head,
   input  kvt_pkg::queue_status_type q_stat,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2:0]                rsp_token_kind,
   output logic [7:0]                rsp_token_char,
   output logic                      rsp_run_end
);

   logic [1:0]              idx_ff, idx_in;
   logic                    valid_ff, valid_in;
   kvt_pkg::token_kind_type kind_ff;
   logic [7:0]              char_ff;
   logic                    run_end_ff;
   logic                    load;
   logic                    last;

   assign last  = (idx_ff == head.cnt - 2'd1);
   assign load  = !q_stat.empty && (!valid_ff || rsp_ready);
   assign q_pop = load && last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = last ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff    <= head.kind[idx_ff];
         char_ff    <= (idx_ff == 2'd0) ? head.chr : 8'd0;
         run_end_ff <= last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_token_kind = kind_ff;
   assign rsp_token_char = char_ff;
   assign rsp_run_end    = run_end_ff;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench of the key/value string tokenizer core
module testbench;

   localparam int PREDICTED = -1;
   localparam int FLUSH_CYCLES = 8;
   localparam int QUIET_LIMIT = 400;
   localparam int BYTES_PER_SETTING = 34;
   localparam int NUM_SETTINGS = 8;
   localparam int NUM_ROWS = 25;

   typedef struct {
      kvt_pkg::token_kind_type kind;
      logic [7:0]              chr;
      logic                    last;
   } token_type;

   typedef struct {
      logic [7:0]              chr;
      logic                    fin;
      int                      want_n;
      kvt_pkg::token_kind_type want_last;
   } script_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_char_in = 8'h00;
   logic       req_is_final = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_token_kind;
   logic [7:0] rsp_token_char;
   logic       rsp_run_end;
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = 8'h00;

   // tokenizer state as the block should hold it
   kvt_pkg::phase_type parse_phase = kvt_pkg::PH_NAME;
   logic               name_seen = 1'b0;
   logic [7:0]         sep_reg = kvt_pkg::SEP_RESET;

   token_type  pending_tokens[$];
   logic [8:0] line_q[$];
   int         fail_count = 0;
   int         tokens_seen = 0;
   int         bytes_sent = 0;
   int         stall_left = 0;
   logic       src_idle_on = 1'b0;
   logic       sink_idle_on = 1'b1;

   logic [7:0] sep_plan [NUM_SETTINGS] =
      '{kvt_pkg::SEP_RESET, 8'h00, kvt_pkg::CH_EQ, kvt_pkg::CH_QUOTE, kvt_pkg::CH_BSLASH,
        8'hFF, 8'h00, kvt_pkg::SEP_RESET};

   script_row_type script [NUM_ROWS] = '{
      '{8'h61,              1'b0, 1,         kvt_pkg::TK_NAME_CHAR},
      '{8'h00,              1'b0, PREDICTED, kvt_pkg::TK_NAME_CHAR},
      '{kvt_pkg::CH_EQ,     1'b0, 1,         kvt_pkg::TK_NAME_END},
      '{8'h00,              1'b0, 1,         kvt_pkg::TK_VALUE_CHAR},
      '{8'hFF,              1'b0, 1,         kvt_pkg::TK_VALUE_CHAR},
      '{kvt_pkg::CH_BSLASH, 1'b0, 0,         kvt_pkg::TK_VALUE_CHAR},
      '{kvt_pkg::SEP_RESET, 1'b0, PREDICTED, kvt_pkg::TK_VALUE_CHAR},
      '{kvt_pkg::CH_QUOTE,  1'b0, 0,         kvt_pkg::TK_VALUE_CHAR},
      '{kvt_pkg::SEP_RESET, 1'b0, PREDICTED, kvt_pkg::TK_VALUE_CHAR},
      '{kvt_pkg::CH_BSLASH, 1'b0, 0,         kvt_pkg::TK_VALUE_CHAR},
      '{kvt_pkg::CH_QUOTE,  1'b0, PREDICTED, kvt_pkg::TK_VALUE_CHAR},
      '{kvt_pkg::CH_QUOTE,  1'b0, 0,         kvt_pkg::TK_VALUE_CHAR},
      '{8'h78,              1'b0, 1,         kvt_pkg::TK_DONE_ERR},
      '{8'h79,              1'b1, 0,         kvt_pkg::TK_DONE_ERR},
      '{8'h6B,              1'b0, PREDICTED, kvt_pkg::TK_NAME_CHAR},
      '{kvt_pkg::CH_EQ,     1'b0, PREDICTED, kvt_pkg::TK_NAME_END},
      '{kvt_pkg::CH_QUOTE,  1'b0, PREDICTED, kvt_pkg::TK_VALUE_CHAR},
      '{kvt_pkg::CH_QUOTE,  1'b0, PREDICTED, kvt_pkg::TK_VALUE_CHAR},
      '{kvt_pkg::SEP_RESET, 1'b1, 2,         kvt_pkg::TK_DONE_OK},
      '{8'h6E,              1'b1, 2,         kvt_pkg::TK_DONE_ERR},
      '{kvt_pkg::CH_EQ,     1'b1, 3,         kvt_pkg::TK_DONE_OK},
      '{kvt_pkg::CH_EQ,     1'b0, PREDICTED, kvt_pkg::TK_NAME_END},
      '{kvt_pkg::CH_QUOTE,  1'b1, 2,         kvt_pkg::TK_DONE_OK},
      '{kvt_pkg::CH_EQ,     1'b0, PREDICTED, kvt_pkg::TK_NAME_END},
      '{kvt_pkg::CH_BSLASH, 1'b1, 2,         kvt_pkg::TK_DONE_OK}
   };

   key_value_string_tokenizer_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_char_in    (req_char_in),
      .req_is_final   (req_is_final),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_token_kind (rsp_token_kind),
      .rsp_token_char (rsp_token_char),
      .rsp_run_end    (rsp_run_end),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void note_failure(input string what);
      fail_count++;
      if (fail_count <= 10) $display("mismatch: %s", what);
   endfunction

   function automatic void add_token(input kvt_pkg::token_kind_type kind,
                                     input logic [7:0] chr);
      token_type t;
      t.kind = kind;
      t.chr  = (kind == kvt_pkg::TK_NAME_CHAR || kind == kvt_pkg::TK_VALUE_CHAR) ?
               chr : 8'h00;
      t.last = 1'b0;
      pending_tokens.push_back(t);
   endfunction

   // advance the tokenizer by one byte, queue its tokens, return how many
   function automatic int tokenize_byte(input logic [7:0] c, input logic fin);
      int   n0;
      logic failed;
      n0 = pending_tokens.size();
      failed = 1'b0;
      case (parse_phase)
         kvt_pkg::PH_NAME: begin
            if (c == kvt_pkg::CH_EQ) begin
               add_token(kvt_pkg::TK_NAME_END, 8'h00);
               parse_phase = kvt_pkg::PH_VAL;
               name_seen = 1'b0;
            end else begin
               add_token(kvt_pkg::TK_NAME_CHAR, c);
               name_seen = 1'b1;
            end
         end
         kvt_pkg::PH_VAL: begin
            if (c == sep_reg) begin
               add_token(kvt_pkg::TK_VALUE_END, 8'h00);
               parse_phase = kvt_pkg::PH_NAME;
               name_seen = 1'b0;
            end else if (c == kvt_pkg::CH_QUOTE) begin
               parse_phase = kvt_pkg::PH_VALQ;
            end else if (c == kvt_pkg::CH_BSLASH) begin
               parse_phase = kvt_pkg::PH_ESC;
            end else begin
               add_token(kvt_pkg::TK_VALUE_CHAR, c);
            end
         end
         kvt_pkg::PH_VALQ: begin
            if (c == kvt_pkg::CH_QUOTE) begin
               parse_phase = kvt_pkg::PH_CLOSED;
            end else if (c == kvt_pkg::CH_BSLASH) begin
               parse_phase = kvt_pkg::PH_ESCQ;
            end else begin
               add_token(kvt_pkg::TK_VALUE_CHAR, c);
            end
         end
         kvt_pkg::PH_ESC: begin
            add_token(kvt_pkg::TK_VALUE_CHAR, c);
            parse_phase = kvt_pkg::PH_VAL;
         end
         kvt_pkg::PH_ESCQ: begin
            add_token(kvt_pkg::TK_VALUE_CHAR, c);
            parse_phase = kvt_pkg::PH_VALQ;
         end
         kvt_pkg::PH_CLOSED: begin
            if (c == sep_reg) begin
               add_token(kvt_pkg::TK_VALUE_END, 8'h00);
               parse_phase = kvt_pkg::PH_NAME;
               name_seen = 1'b0;
            end else begin
               add_token(kvt_pkg::TK_DONE_ERR, 8'h00);
               parse_phase = kvt_pkg::PH_SKIP;
               failed = 1'b1;
            end
         end
         default: begin
            failed = 1'b1;
         end
      endcase
      if (fin) begin
         if (!failed) begin
            if (parse_phase == kvt_pkg::PH_NAME) begin
               add_token(name_seen ? kvt_pkg::TK_DONE_ERR : kvt_pkg::TK_DONE_OK, 8'h00);
            end else begin
               add_token(kvt_pkg::TK_VALUE_END, 8'h00);
               add_token(kvt_pkg::TK_DONE_OK, 8'h00);
            end
         end
         parse_phase = kvt_pkg::PH_NAME;
         name_seen = 1'b0;
      end
      if (pending_tokens.size() > n0) pending_tokens[pending_tokens.size() - 1].last = 1'b1;
      return pending_tokens.size() - n0;
   endfunction

   // one string: mostly name=value pairs with random content, some broken, some noise
   function automatic void compose_line();
      int         style;
      int         pairs;
      int         nlen;
      int         nseg;
      int         nq;
      logic [7:0] b;
      line_q.delete();
      style = $urandom_range(0, 9);
      if (style == 0) begin
         nlen = $urandom_range(1, 6);
         repeat (nlen) line_q.push_back({1'($urandom_range(0, 3) == 0), 8'($urandom)});
      end else begin
         pairs = $urandom_range(1, 3);
         for (int p = 0; p < pairs; p++) begin
            nlen = $urandom_range(1, 4);
            repeat (nlen) begin
               do b = 8'($urandom); while (b == kvt_pkg::CH_EQ);
               line_q.push_back({1'b0, b});
            end
            line_q.push_back({1'b0, kvt_pkg::CH_EQ});
            nseg = $urandom_range(0, 3);
            repeat (nseg) begin
               if ($urandom_range(0, 3) == 0) begin
                  line_q.push_back({1'b0, kvt_pkg::CH_BSLASH});
                  line_q.push_back({1'b0, 8'($urandom)});
               end else begin
                  do b = 8'($urandom);
                  while (b == sep_reg || b == kvt_pkg::CH_QUOTE || b == kvt_pkg::CH_BSLASH);
                  line_q.push_back({1'b0, b});
               end
            end
            if ($urandom_range(0, 2) == 0) begin
               line_q.push_back({1'b0, kvt_pkg::CH_QUOTE});
               nq = $urandom_range(0, 3);
               repeat (nq) begin
                  b = 8'($urandom);
                  if (b == kvt_pkg::CH_QUOTE || b == kvt_pkg::CH_BSLASH)
                     line_q.push_back({1'b0, kvt_pkg::CH_BSLASH});
                  line_q.push_back({1'b0, b});
               end
               if ($urandom_range(0, 5) != 0) line_q.push_back({1'b0, kvt_pkg::CH_QUOTE});
            end
            if (p < pairs - 1 || $urandom_range(0, 3) == 0) line_q.push_back({1'b0, sep_reg});
         end
         if (style == 1) line_q[$urandom_range(0, line_q.size() - 1)] = {1'b0, 8'($urandom)};
      end
      line_q[line_q.size() - 1][8] = 1'b1;
   endfunction

   task automatic send_byte(input logic [7:0] c, input logic fin, output int n);
      req_valid    <= 1'b1;
      req_char_in  <= c;
      req_is_final <= fin;
      do @(posedge clock); while (!req_ready);
      n = tokenize_byte(c, fin);
      bytes_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_tokens();
      req_valid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (FLUSH_CYCLES) @(posedge clock);
   endtask

   task automatic write_separator(input logic [7:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sep_reg = value;
   endtask

   // result side: check each token beat, stall in random bursts
   always @(posedge clock) begin
      token_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         tokens_seen++;
         if (pending_tokens.size() == 0) begin
            note_failure($sformatf("unexpected token kind %0d char %02h run_end %0b",
                                   rsp_token_kind, rsp_token_char, rsp_run_end));
         end else begin
            want = pending_tokens.pop_front();
            if (rsp_token_kind !== 3'(want.kind) || rsp_token_char !== want.chr ||
                rsp_run_end !== want.last)
               note_failure($sformatf(
                  "token %0d: expected kind %0d char %02h run_end %0b, got %0d %02h %0b",
                  tokens_seen, want.kind, want.chr, want.last,
                  rsp_token_kind, rsp_token_char, rsp_run_end));
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         if (stall_left == 0) rsp_ready <= 1'b1;
      end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 18);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog on cycles without any beat
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int   n;
      int   start;
      logic held;
      held = 1'b0;
      sep_plan[6] = 8'($urandom);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_ROWS; i++) begin
         send_byte(script[i].chr, script[i].fin, n);
         if (script[i].want_n != PREDICTED && (n != script[i].want_n ||
             (n > 0 && pending_tokens[pending_tokens.size() - 1].kind != script[i].want_last)))
            note_failure($sformatf("row %0d: expected %0d tokens ending in kind %0d, got %0d",
                                   i, script[i].want_n, script[i].want_last, n));
      end

      for (int s = 0; s < NUM_SETTINGS; s++) begin
         drain_tokens();
         write_separator(sep_plan[s]);
         src_idle_on  = (s < NUM_SETTINGS - 1) && (s == 0 || $urandom_range(0, 3) != 0);
         sink_idle_on = (s < NUM_SETTINGS - 1) && (s == 0 || $urandom_range(0, 3) != 0);
         start = bytes_sent;
         while (bytes_sent - start < BYTES_PER_SETTING) begin
            compose_line();
            foreach (line_q[j]) begin
               send_byte(line_q[j][7:0], line_q[j][8], n);
               if (src_idle_on && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 18));
            end
            if (s == 3 && !held) begin
               held = 1'b1;
               drain_tokens();
            end
         end
      end

      drain_tokens();
      if (pending_tokens.size() != 0)
         note_failure($sformatf("%0d tokens never arrived", pending_tokens.size()));
      $display("sent %0d bytes (%0d directed, rest random under %0d separator settings)",
               bytes_sent, NUM_ROWS, NUM_SETTINGS);
      $display("checked %0d tokens, %0d mismatches", tokens_seen, fail_count);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
